// ===== sv/cmvg_pkg.sv =====
package cmvg_pkg;

  // store and counter geometry
  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = 10;
  localparam int CNT_W       = 9;
  localparam int QUEUE_DEPTH = 4;

  // raster timing defaults
  localparam int DEF_H_TOTAL        = 416;
  localparam int DEF_V_TOTAL        = 264;
  localparam int DEF_H_ACTIVE       = 256;
  localparam int DEF_V_ACTIVE       = 192;
  localparam int DEF_IRQ_FIRST_LINE = 248;
  localparam int IRQ_LINES          = 8;

  // bus decode: top five address bits select a 2K region
  localparam logic [4:0] SCREEN_REGION  = 5'b00100;
  localparam logic [4:0] PATTERN_REGION = 5'b00101;

  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam int         INVERT_BIT = 7;

  // bus commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // decoded operation kinds
  typedef enum logic [4:0] {
    KIND_NONE   = 5'b00001,
    KIND_TICK   = 5'b00010,
    KIND_SCR_WR = 5'b00100,
    KIND_PAT_WR = 5'b01000,
    KIND_SCR_RD = 5'b10000
  } kind_t;

  // one queued beat after decode
  typedef struct packed {
    kind_t               kind;
    logic [STORE_AW-1:0] idx;
    logic [7:0]          data;
  } qentry_t;

endpackage

// ===== sv/character_mapped_video_generator.sv =====
// Character-mapped video generator with a CPU bus port. Each beat is a pixel tick, a bus
// write, a bus read or an unused code, and gives exactly one result beat. Bus writes to
// 0x2000-0x27FF fill the 1K screen store and writes to 0x2800-0x2FFF the 1K pattern store
// (address mod 1024); reads of the screen region return its byte, all other reads return
// 0xFF. A tick emits the pixel at the current raster position and then advances it. The
// block takes one beat per clock while in_stall is low: beats pass a four-entry queue into
// a three-stage pipeline (screen store read, pattern store read, output register), each
// store being a single-port RAM touched in one fixed stage. After reset a clearing pass
// writes zero to every entry of both stores, during which in_stall is high.
module character_mapped_video_generator #(
  parameter int H_TOTAL        = cmvg_pkg::DEF_H_TOTAL,
  parameter int V_TOTAL        = cmvg_pkg::DEF_V_TOTAL,
  parameter int H_ACTIVE       = cmvg_pkg::DEF_H_ACTIVE,
  parameter int V_ACTIVE       = cmvg_pkg::DEF_V_ACTIVE,
  parameter int IRQ_FIRST_LINE = cmvg_pkg::DEF_IRQ_FIRST_LINE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pixel,
  output logic        visible,
  output logic        irq,
  output logic [7:0]  read_data
);
  import cmvg_pkg::*;

  qentry_t head;
  logic    head_valid;
  logic    pop;
  logic    clearing;

  // decode and queue
  cmvg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .address    (address),
    .data       (data),
    .clearing   (clearing),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // raster, stores and result pipeline
  cmvg_back #(
    .H_TOTAL        (H_TOTAL),
    .V_TOTAL        (V_TOTAL),
    .H_ACTIVE       (H_ACTIVE),
    .V_ACTIVE       (V_ACTIVE),
    .IRQ_FIRST_LINE (IRQ_FIRST_LINE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel      (pixel),
    .visible    (visible),
    .irq        (irq),
    .read_data  (read_data)
  );

endmodule

// ===== sv/cmvg_ram.sv =====
module cmvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, read returns the old contents
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/cmvg_front.sv =====
module cmvg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [15:0]       address,
  input  logic [7:0]        data,
  input  logic              clearing,
  input  logic              pop,
  output logic              head_valid,
  output cmvg_pkg::qentry_t head
);
  import cmvg_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qentry_t       q [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  qentry_t       dec;
  logic          push;
  logic          full;

  // decode the incoming beat
  always_comb begin
    dec.idx  = address[STORE_AW-1:0];
    dec.data = data;
    dec.kind = KIND_NONE;
    case (cmd)
      CMD_TICK: dec.kind = KIND_TICK;
      CMD_WRITE: begin
        if (address[15:11] == SCREEN_REGION) begin
          dec.kind = KIND_SCR_WR;
        end else if (address[15:11] == PATTERN_REGION) begin
          dec.kind = KIND_PAT_WR;
        end
      end
      CMD_READ: begin
        if (address[15:11] == SCREEN_REGION) begin
          dec.kind = KIND_SCR_RD;
        end
      end
      default: dec.kind = KIND_NONE;
    endcase
  end

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign in_stall   = full || clearing;
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign head       = q[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= dec;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");
  a_no_push_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !push) else $error("beat taken during clear");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("queue overflow");
`endif

endmodule

// ===== sv/cmvg_back.sv =====
module cmvg_back #(
  parameter int H_TOTAL        = cmvg_pkg::DEF_H_TOTAL,
  parameter int V_TOTAL        = cmvg_pkg::DEF_V_TOTAL,
  parameter int H_ACTIVE       = cmvg_pkg::DEF_H_ACTIVE,
  parameter int V_ACTIVE       = cmvg_pkg::DEF_V_ACTIVE,
  parameter int IRQ_FIRST_LINE = cmvg_pkg::DEF_IRQ_FIRST_LINE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cmvg_pkg::qentry_t head,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              pixel,
  output logic              visible,
  output logic              irq,
  output logic [7:0]        read_data
);
  import cmvg_pkg::*;

  localparam logic [CNT_W-1:0] HT  = CNT_W'(H_TOTAL);
  localparam logic [CNT_W-1:0] VT  = CNT_W'(V_TOTAL);
  localparam logic [CNT_W-1:0] HA  = CNT_W'(H_ACTIVE);
  localparam logic [CNT_W-1:0] VA  = CNT_W'(V_ACTIVE);
  localparam logic [CNT_W-1:0] IRQ_LO = CNT_W'(IRQ_FIRST_LINE);
  localparam logic [CNT_W-1:0] IRQ_HI = CNT_W'(IRQ_FIRST_LINE + IRQ_LINES);

  logic [STORE_AW-1:0] clr_idx;
  logic                adv;
  logic                tick;
  logic [CNT_W-1:0]    col;
  logic [CNT_W-1:0]    line;
  logic [CNT_W-1:0]    col_next;
  logic [CNT_W-1:0]    line_next;
  logic [CNT_W-1:0]    line_after;
  logic                vis_now;
  logic                irq_now;

  logic                s_en;
  logic                s_we;
  logic [STORE_AW-1:0] s_addr;
  logic [7:0]          s_wdata;
  logic [7:0]          s_q;
  logic                p_en;
  logic                p_we;
  logic [STORE_AW-1:0] p_addr;
  logic [7:0]          p_wdata;
  logic [7:0]          p_q;

  logic                p1_valid;
  kind_t               p1_kind;
  logic [STORE_AW-1:0] p1_idx;
  logic [7:0]          p1_data;
  logic                p1_vis;
  logic                p1_irq;
  logic [2:0]          p1_line_lo;
  logic [2:0]          p1_col_lo;

  logic                p2_valid;
  logic                p2_vis;
  logic                p2_irq;
  logic [2:0]          p2_col_lo;
  logic                p2_inv;
  logic [7:0]          p2_rd;

  // clearing pass over both stores after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // whole pipeline moves when the output register can take a beat
  assign adv  = !out_valid || !out_stall;
  assign pop  = adv && head_valid && !clearing;
  assign tick = pop && (head.kind == KIND_TICK);

  // raster advance
  always_comb begin
    col_next  = col + 1'b1;
    line_next = line;
    if (col_next >= HT) begin
      col_next  = '0;
      line_next = line + 1'b1;
      if (line_next >= VT) begin
        line_next = '0;
      end
    end
  end

  assign vis_now    = (col < HA) && (line < VA);
  assign line_after = tick ? line_next : line;
  assign irq_now    = (line_after >= IRQ_LO) && (line_after < IRQ_HI);

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      line <= '0;
    end else if (tick) begin
      col  <= col_next;
      line <= line_next;
    end
  end

  // stage 1: screen store access
  always_comb begin
    s_en    = adv || clearing;
    s_we    = clearing || (pop && (head.kind == KIND_SCR_WR));
    s_wdata = clearing ? 8'h00 : head.data;
    if (clearing) begin
      s_addr = clr_idx;
    end else if (head.kind == KIND_TICK) begin
      s_addr = {line[7:3], col[7:3]};
    end else begin
      s_addr = head.idx;
    end
  end

  cmvg_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_screen (
    .clk   (clk),
    .en    (s_en),
    .we    (s_we),
    .addr  (s_addr),
    .wdata (s_wdata),
    .rdata (s_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_kind    <= head.kind;
      p1_idx     <= head.idx;
      p1_data    <= head.data;
      p1_vis     <= tick && vis_now;
      p1_irq     <= irq_now;
      p1_line_lo <= line[2:0];
      p1_col_lo  <= col[2:0];
    end
  end

  // stage 2: pattern store access
  always_comb begin
    p_en    = adv || clearing;
    p_we    = clearing || (adv && p1_valid && (p1_kind == KIND_PAT_WR));
    p_wdata = clearing ? 8'h00 : p1_data;
    if (clearing) begin
      p_addr = clr_idx;
    end else if (p1_kind == KIND_PAT_WR) begin
      p_addr = p1_idx;
    end else begin
      p_addr = {s_q[6:0], p1_line_lo};
    end
  end

  cmvg_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_pattern (
    .clk   (clk),
    .en    (p_en),
    .we    (p_we),
    .addr  (p_addr),
    .wdata (p_wdata),
    .rdata (p_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_vis    <= p1_vis;
      p2_irq    <= p1_irq;
      p2_col_lo <= p1_col_lo;
      p2_inv    <= s_q[INVERT_BIT];
      p2_rd     <= (p1_kind == KIND_SCR_RD) ? s_q : IDLE_BYTE;
    end
  end

  // stage 3: pixel select and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel     <= p2_vis && (p_q[~p2_col_lo] ^ p2_inv);
      visible   <= p2_vis;
      irq       <= p2_irq;
      read_data <= p2_rd;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop) else $error("item issued during clear");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (col < HT) && (line < VT)) else $error("raster position out of range");
  a_vis_no_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && visible) |-> (read_data == IDLE_BYTE))
    else $error("visible beat carries read data");
  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(p1_valid) && $stable(p2_valid))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ===== sim/tb_character_mapped_video_generator.sv =====
`timescale 1ns / 100ps

module tb_character_mapped_video_generator;
  import cmvg_pkg::*;

  localparam logic [1:0]  CMD_NOP      = 2'd3;
  localparam logic [15:0] SCREEN_BASE  = 16'h2000;
  localparam logic [15:0] PATTERN_BASE = 16'h2800;

  localparam int SEND_GAP_MAX  = 19;
  localparam int RECV_GAP_MAX  = 19;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_BEATS  = 1100;
  localparam int MAX_REPORTS   = 50;
  localparam int SWEEP_TICKS   = DEF_H_TOTAL + 8;

  // one bus beat waiting to be sent, with its lead-in gap
  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    int          gap;
    bit          drain;
  } bus_beat_t;

  // one result beat of the video generator
  typedef struct {
    logic       pixel;
    logic       visible;
    logic       irq;
    logic [7:0] read_data;
  } video_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_TICK;
  logic [15:0] address = '0;
  logic [7:0]  data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        pixel;
  logic        visible;
  logic        irq;
  logic [7:0]  read_data;

  // shadow of the display state
  logic [7:0] screen_mem [STORE_DEPTH];
  logic [7:0] pattern_mem [STORE_DEPTH];
  logic [8:0] raster_col;
  logic [8:0] raster_line;

  bus_beat_t  bus_beat_q[$];
  video_out_t video_out_q[$];

  bit offering;
  bit armed;
  int wait_left;
  int beats_sent;
  int results_taken;
  int results_seen;
  int recv_wait;
  int idle_cycles;
  int mismatches;
  int hold_at;
  int sweep_first;
  int sweep_last;
  int n_ticks, n_visible, n_lit, n_irq, n_frames, n_scr_wr, n_pat_wr, n_reads;

  character_mapped_video_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .address   (address),
    .data      (data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel),
    .visible   (visible),
    .irq       (irq),
    .read_data (read_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // work out the result of one accepted beat and update the shadow state
  task automatic compute_video_out(input logic [1:0] op, input logic [15:0] addr,
                                   input logic [7:0] wdata);
    video_out_t r;
    logic [9:0] cell_idx;
    logic [9:0] prow;
    logic [7:0] code;
    logic [7:0] bits;
    r.pixel     = 1'b0;
    r.visible   = 1'b0;
    r.read_data = IDLE_BYTE;
    case (op)
      CMD_TICK: begin
        n_ticks++;
        if (raster_col < DEF_H_ACTIVE && raster_line < DEF_V_ACTIVE) begin
          cell_idx  = 10'((raster_line >> 3) * 32 + (raster_col >> 3));
          code      = screen_mem[cell_idx];
          prow      = {code[6:0], raster_line[2:0]};
          bits      = pattern_mem[prow];
          r.pixel   = bits[3'd7 - raster_col[2:0]] ^ code[INVERT_BIT];
          r.visible = 1'b1;
          n_visible++;
          if (r.pixel) n_lit++;
        end
        // step the raster, wrapping column then line
        raster_col = raster_col + 9'd1;
        if (raster_col >= DEF_H_TOTAL) begin
          raster_col  = '0;
          raster_line = raster_line + 9'd1;
          if (raster_line >= DEF_V_TOTAL) begin
            raster_line = '0;
            n_frames++;
          end
        end
      end
      CMD_WRITE: begin
        if (addr[15:11] == SCREEN_REGION) begin
          screen_mem[addr[9:0]] = wdata;
          n_scr_wr++;
        end else if (addr[15:11] == PATTERN_REGION) begin
          pattern_mem[addr[9:0]] = wdata;
          n_pat_wr++;
        end
      end
      CMD_READ: begin
        n_reads++;
        if (addr[15:11] == SCREEN_REGION) r.read_data = screen_mem[addr[9:0]];
      end
      default: ;
    endcase
    r.irq = (raster_line >= DEF_IRQ_FIRST_LINE) &&
            (raster_line < DEF_IRQ_FIRST_LINE + IRQ_LINES);
    if (op == CMD_TICK && r.irq) n_irq++;
    video_out_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic push_beat(input logic [1:0] op, input logic [15:0] addr,
                           input logic [7:0] wdata);
    bus_beat_t b;
    b.cmd   = op;
    b.addr  = addr;
    b.data  = wdata;
    b.gap   = $urandom_range(0, SEND_GAP_MAX);
    b.drain = 1'b0;
    bus_beat_q.push_back(b);
  endtask

  // random beat: ticks and store traffic near the raster, some stray addresses
  function automatic bus_beat_t random_bus_beat(input bit wide, input int gap);
    bus_beat_t b;
    int pick;
    int sel;
    b.addr  = 16'($urandom_range(0, 65535));
    b.data  = 8'($urandom_range(0, 255));
    b.gap   = gap;
    b.drain = 1'b0;
    pick    = $urandom_range(0, 99);
    sel     = $urandom_range(0, 9);
    if (pick < 45) begin
      b.cmd = CMD_TICK;
    end else if (pick < 72) begin
      b.cmd = CMD_WRITE;
      if (sel < 4)
        b.addr = SCREEN_BASE + 16'(wide ? $urandom_range(0, 767) : $urandom_range(0, 63));
      else if (sel < 8)
        b.addr = PATTERN_BASE + {6'd0, 7'($urandom),
                                 wide ? 3'($urandom) : 3'($urandom_range(0, 1))};
      // upper alias of either store
      if (sel < 8 && $urandom_range(0, 3) == 0) b.addr[10] = 1'b1;
    end else if (pick < 95) begin
      b.cmd = CMD_READ;
      if (sel < 7)
        b.addr = SCREEN_BASE + 16'($urandom_range(0, 2047));
      else if (sel == 7)
        b.addr = PATTERN_BASE + 16'($urandom_range(0, 2047));
    end else begin
      b.cmd = CMD_NOP;
    end
    return b;
  endfunction

  // sender: waits out each beat's gap, holds the beat until accepted
  always @(posedge clk) begin
    bus_beat_t nxt;
    if (rst) begin
      in_valid    <= 1'b0;
      offering    = 1'b0;
      armed       = 1'b0;
      wait_left   = 0;
      beats_sent  = 0;
      raster_col  = '0;
      raster_line = '0;
      foreach (screen_mem[i]) screen_mem[i] = '0;
      foreach (pattern_mem[i]) pattern_mem[i] = '0;
    end else begin
      if (in_valid && !in_stall) begin
        compute_video_out(cmd, address, data);
        beats_sent++;
        offering = 1'b0;
      end
      if (!offering && bus_beat_q.size() != 0) begin
        if (!armed) begin
          wait_left = bus_beat_q[0].gap;
          armed     = 1'b1;
        end
        if (wait_left > 0) begin
          wait_left--;
        end else if (!bus_beat_q[0].drain || beats_sent == results_seen) begin
          nxt = bus_beat_q.pop_front();
          cmd      <= nxt.cmd;
          address  <= nxt.addr;
          data     <= nxt.data;
          offering = 1'b1;
          armed    = 1'b0;
        end
      end
      in_valid <= offering;
    end
  end

  // receiver: checks each result beat, then stalls for a drawn number of cycles
  always @(posedge clk) begin
    video_out_t want;
    if (rst) begin
      out_stall     <= 1'b0;
      results_seen  <= 0;
      results_taken = 0;
      recv_wait     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_taken++;
        if (video_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: result beat arrived with nothing expected", $time);
        end else begin
          want = video_out_q.pop_front();
          check_field("pixel", want.pixel, pixel);
          check_field("visible", want.visible, visible);
          check_field("irq", want.irq, irq);
          check_field("read_data", want.read_data, read_data);
        end
        if (results_taken == hold_at)
          recv_wait = LONG_HOLD;
        else if ((results_taken >= sweep_first && results_taken < sweep_last) ||
                 (results_taken / 128) % 4 == 0)
          recv_wait = 0;
        else
          recv_wait = $urandom_range(0, RECV_GAP_MAX);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall    <= (recv_wait != 0);
      results_seen <= results_taken;
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    bus_beat_t b;
    bit quiet;
    int sweep_ticks;

    // directed: cleared stores, aliasing, region edges, stray and unused commands
    push_beat(CMD_READ, 16'h2000, 8'h00);
    push_beat(CMD_TICK, 16'h0000, 8'h00);
    push_beat(CMD_WRITE, 16'h2400, 8'h55);
    push_beat(CMD_READ, 16'h2000, 8'hFF);
    push_beat(CMD_WRITE, 16'h2000, 8'h81);
    push_beat(CMD_WRITE, 16'h2808, 8'h80);
    push_beat(CMD_WRITE, 16'h2FFF, 8'hFF);
    push_beat(CMD_WRITE, 16'h27FF, 8'hA5);
    push_beat(CMD_READ, 16'h27FF, 8'h00);
    push_beat(CMD_WRITE, 16'h1FFF, 8'h00);
    push_beat(CMD_WRITE, 16'h3000, 8'hFF);
    push_beat(CMD_WRITE, 16'hFFFF, 8'hFF);
    push_beat(CMD_WRITE, 16'h0000, 8'h00);
    push_beat(CMD_READ, 16'h2800, 8'h00);
    push_beat(CMD_READ, 16'h1FFF, 8'h00);
    push_beat(CMD_READ, 16'hFFFF, 8'hFF);
    push_beat(CMD_NOP, 16'hFFFF, 8'hFF);
    push_beat(CMD_NOP, 16'h2000, 8'h00);
    repeat (4) push_beat(CMD_TICK, 16'hFFFF, 8'hFF);
    push_beat(CMD_READ, 16'h2400, 8'h00);

    // random traffic, the first beat waits for the directed results
    hold_at = bus_beat_q.size() + 300;
    quiet   = 1'b0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      b = random_bus_beat(1'b0, quiet ? 0 : $urandom_range(0, SEND_GAP_MAX));
      b.drain = (i == 0);
      bus_beat_q.push_back(b);
    end

    // back-to-back sweep over a full raster line and its column wrap
    sweep_first = bus_beat_q.size();
    sweep_ticks = 0;
    while (sweep_ticks < SWEEP_TICKS) begin
      b = random_bus_beat(1'b1, 0);
      if ($urandom_range(0, 31) != 0) b.cmd = CMD_TICK;
      b.drain = (bus_beat_q.size() == sweep_first);
      if (b.cmd == CMD_TICK) sweep_ticks++;
      bus_beat_q.push_back(b);
    end
    sweep_last = bus_beat_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (bus_beat_q.size() == 0 && !offering && beats_sent == results_seen);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("raster: %0d ticks, %0d visible, %0d lit, %0d in irq lines, %0d frame wraps",
             n_ticks, n_visible, n_lit, n_irq, n_frames);
    $display("bus: %0d screen writes, %0d pattern writes, %0d reads; %0d beats checked",
             n_scr_wr, n_pat_wr, n_reads, results_taken);
    if (mismatches == 0 && video_out_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cmvg_pkg.sv
sv/cmvg_ram.sv
sv/cmvg_front.sv
sv/cmvg_back.sv
sv/character_mapped_video_generator.sv
sim/tb_character_mapped_video_generator.sv
